// ===== hw/rtl/best_fit_pool_allocator_unit_defines.svh =====
// Assertion macros for the best-fit pool allocator.
`ifndef BEST_FIT_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define BEST_FIT_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// Property checked outside reset.
`define BFPA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bfpa check failed");

// Property checked on every edge, reset included.
`define BFPA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bfpa check failed");

`endif

// ===== hw/rtl/bfpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bfpa_pkg;

  localparam int POOL_BYTES    = 4096;
  localparam int GRANULE_BYTES = 8;
  localparam int HEADER_BYTES  = 32;
  localparam int NGRAN         = POOL_BYTES / GRANULE_BYTES;
  localparam int GW            = $clog2(NGRAN);
  localparam int SZW           = GW + 1;
  localparam int GSH           = $clog2(GRANULE_BYTES);

  localparam logic [2:0] ADDR_MIN_SPLIT = 3'd0;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADREQ  = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ,
    OP_READ_NEXT,
    OP_ALLOC_EVAL,
    OP_ALLOC_WR1,
    OP_ALLOC_WR2,
    OP_FREE_EVAL,
    OP_FREE_HIT,
    OP_FREE_NLATCH,
    OP_FREE_WRITE,
    OP_STAT_INIT,
    OP_STAT_EVAL,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t     op;
    logic    set_st;
    status_t st;
  } cmd_t;

  typedef struct packed {
    logic alloc;
    logic bad_req;
    logic ptr_end;
    logic ptr_hit;
    logic ptr_past;
    logic cur_used;
    logic best_ok;
    logic do_split;
    logic next_in_pool;
    logic out_free;
  } flags_t;

endpackage

// ===== hw/rtl/bfpa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_ctrl
// Sequencer for allocate, free and the statistics walk over the block chain.
// ----------------------------------------------------------------------------
module bfpa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bfpa_pkg::flags_t flags,
  output bfpa_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_A_RD, S_A_EV, S_A_W1, S_A_W2,
    S_F_RD, S_F_EV, S_F_NRD, S_F_NEV, S_F_WR,
    S_S_INIT, S_S_RD, S_S_EV, S_DONE
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = bfpa_pkg::OP_NONE;
    cmd.set_st = 1'b0;
    cmd.st     = bfpa_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = bfpa_pkg::OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (flags.bad_req) begin
          cmd.set_st = 1'b1;
          cmd.st     = flags.alloc ? bfpa_pkg::ST_BADREQ : bfpa_pkg::ST_BADFREE;
          state_next = S_S_INIT;
        end else begin
          state_next = flags.alloc ? S_A_RD : S_F_RD;
        end
      end
      S_A_RD: begin
        if (flags.ptr_end) begin
          if (flags.best_ok) begin
            state_next = S_A_W1;
          end else begin
            cmd.set_st = 1'b1;
            cmd.st     = bfpa_pkg::ST_NOFIT;
            state_next = S_S_INIT;
          end
        end else begin
          cmd.op     = bfpa_pkg::OP_READ;
          state_next = S_A_EV;
        end
      end
      S_A_EV: begin
        cmd.op     = bfpa_pkg::OP_ALLOC_EVAL;
        state_next = S_A_RD;
      end
      S_A_W1: begin
        cmd.op     = bfpa_pkg::OP_ALLOC_WR1;
        cmd.set_st = 1'b1;
        cmd.st     = bfpa_pkg::ST_OK;
        state_next = flags.do_split ? S_A_W2 : S_S_INIT;
      end
      S_A_W2: begin
        cmd.op     = bfpa_pkg::OP_ALLOC_WR2;
        state_next = S_S_INIT;
      end
      S_F_RD: begin
        if (flags.ptr_end || flags.ptr_past) begin
          cmd.set_st = 1'b1;
          cmd.st     = bfpa_pkg::ST_BADFREE;
          state_next = S_S_INIT;
        end else begin
          cmd.op     = bfpa_pkg::OP_READ;
          state_next = S_F_EV;
        end
      end
      S_F_EV: begin
        if (flags.ptr_hit) begin
          if (flags.cur_used) begin
            cmd.op     = bfpa_pkg::OP_FREE_HIT;
            state_next = S_F_NRD;
          end else begin
            cmd.set_st = 1'b1;
            cmd.st     = bfpa_pkg::ST_BADFREE;
            state_next = S_S_INIT;
          end
        end else begin
          cmd.op     = bfpa_pkg::OP_FREE_EVAL;
          state_next = S_F_RD;
        end
      end
      S_F_NRD: begin
        if (flags.next_in_pool) begin
          cmd.op     = bfpa_pkg::OP_READ_NEXT;
          state_next = S_F_NEV;
        end else begin
          state_next = S_F_WR;
        end
      end
      S_F_NEV: begin
        cmd.op     = bfpa_pkg::OP_FREE_NLATCH;
        state_next = S_F_WR;
      end
      S_F_WR: begin
        cmd.op     = bfpa_pkg::OP_FREE_WRITE;
        cmd.set_st = 1'b1;
        cmd.st     = bfpa_pkg::ST_OK;
        state_next = S_S_INIT;
      end
      S_S_INIT: begin
        cmd.op     = bfpa_pkg::OP_STAT_INIT;
        state_next = S_S_RD;
      end
      S_S_RD: begin
        if (flags.ptr_end) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = bfpa_pkg::OP_READ;
          state_next = S_S_EV;
        end
      end
      S_S_EV: begin
        cmd.op     = bfpa_pkg::OP_STAT_EVAL;
        state_next = S_S_RD;
      end
      S_DONE: begin
        if (flags.out_free) begin
          cmd.op     = bfpa_pkg::OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bfpa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_datapath
// Block table memory, walk registers, best-fit search and result register.
// ----------------------------------------------------------------------------
module bfpa_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  bfpa_pkg::cmd_t       cmd,
  output bfpa_pkg::flags_t     flags,
  input  logic                 in_req_type,
  input  logic [12:0]          in_request_bytes,
  input  logic [11:0]          in_release_offset,
  input  logic [12:0]          min_split_bytes,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [11:0]          out_granted_offset,
  output logic [12:0]          out_total_free_bytes,
  output logic [12:0]          out_largest_free_bytes
);

  localparam int GW  = bfpa_pkg::GW;
  localparam int SZW = bfpa_pkg::SZW;
  localparam int NW  = 14;

  // table entry: {used, size in granules}
  logic [SZW:0] mem [bfpa_pkg::NGRAN];
  logic [SZW:0] rdata;
  logic         rd_en;
  logic [GW-1:0] raddr;
  logic         we;
  logic [GW-1:0] waddr;
  logic [SZW:0] wdata;
  logic         rd_zero;
  logic         e0_written;

  logic           alloc;
  logic [NW-1:0]  need;
  logic           bad_req;
  logic [GW-1:0]  fg;
  logic [SZW-1:0] ptr;
  logic [GW-1:0]  best;
  logic [SZW-1:0] best_sz;
  logic           best_ok;
  logic [GW-1:0]  prev;
  logic           prev_ok;
  logic           prev_used;
  logic [SZW-1:0] prev_sz;
  logic [SZW-1:0] g_sz;
  logic           nfree;
  logic [SZW-1:0] nsz;
  logic [SZW-1:0] sum;
  logic [SZW-1:0] maxsz;
  bfpa_pkg::status_t st;

  logic           cur_used;
  logic [SZW-1:0] cur_sz;
  logic [NW-1:0]  need_calc;
  logic [11:0]    off_rel;
  logic [SZW-1:0] left;
  logic [SZW-1:0] merged;
  logic [SZW-1:0] next_g;

  assign cur_used = (rd_zero && !e0_written) ? 1'b0 : rdata[SZW];
  assign cur_sz   = (rd_zero && !e0_written) ? SZW'(bfpa_pkg::NGRAN) : rdata[SZW-1:0];

  assign need_calc = (NW'(in_request_bytes) + NW'(bfpa_pkg::HEADER_BYTES)
                      + NW'(bfpa_pkg::GRANULE_BYTES - 1)) >> bfpa_pkg::GSH;
  assign off_rel   = in_release_offset - 12'(bfpa_pkg::HEADER_BYTES);
  assign left      = best_sz - SZW'(need);
  assign merged    = g_sz + (nfree ? nsz : '0);
  assign next_g    = SZW'(fg) + g_sz;

  assign flags.alloc        = alloc;
  assign flags.bad_req      = bad_req;
  assign flags.ptr_end      = (ptr >= SZW'(bfpa_pkg::NGRAN));
  assign flags.ptr_hit      = (ptr == SZW'(fg));
  assign flags.ptr_past     = (ptr > SZW'(fg));
  assign flags.cur_used     = cur_used;
  assign flags.best_ok      = best_ok;
  assign flags.do_split     = (left != '0) &&
                              (13'({left, bfpa_pkg::GSH'(0)}) >= min_split_bytes);
  assign flags.next_in_pool = (next_g < SZW'(bfpa_pkg::NGRAN));
  assign flags.out_free     = !out_valid || out_ready;

  always_comb begin
    rd_en = 1'b0;
    raddr = ptr[GW-1:0];
    we    = 1'b0;
    waddr = best;
    wdata = {1'b1, best_sz};
    case (cmd.op)
      bfpa_pkg::OP_READ: begin
        rd_en = 1'b1;
      end
      bfpa_pkg::OP_READ_NEXT: begin
        rd_en = 1'b1;
        raddr = next_g[GW-1:0];
      end
      bfpa_pkg::OP_ALLOC_WR1: begin
        we    = 1'b1;
        wdata = {1'b1, flags.do_split ? SZW'(need) : best_sz};
      end
      bfpa_pkg::OP_ALLOC_WR2: begin
        we    = 1'b1;
        waddr = best + GW'(need);
        wdata = {1'b0, left};
      end
      bfpa_pkg::OP_FREE_WRITE: begin
        we = 1'b1;
        if (prev_ok && !prev_used) begin
          waddr = prev;
          wdata = {1'b0, prev_sz + merged};
        end else begin
          waddr = fg;
          wdata = {1'b0, merged};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata   <= mem[raddr];
      rd_zero <= (raddr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e0_written <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (we && waddr == '0) begin
        e0_written <= 1'b1;
      end
      if (cmd.op == bfpa_pkg::OP_RESULT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_st) begin
      st <= cmd.st;
    end
    case (cmd.op)
      bfpa_pkg::OP_LOAD: begin
        alloc   <= !in_req_type;
        need    <= need_calc;
        fg      <= off_rel[GW+bfpa_pkg::GSH-1:bfpa_pkg::GSH];
        ptr     <= '0;
        best_ok <= 1'b0;
        prev_ok <= 1'b0;
        nfree   <= 1'b0;
        if (!in_req_type) begin
          bad_req <= (in_request_bytes == '0) ||
                     (need_calc > NW'(bfpa_pkg::NGRAN));
        end else begin
          bad_req <= (in_release_offset < 12'(bfpa_pkg::HEADER_BYTES)) ||
                     (off_rel[bfpa_pkg::GSH-1:0] != '0);
        end
      end
      bfpa_pkg::OP_ALLOC_EVAL: begin
        if (!cur_used && NW'(cur_sz) >= need && (!best_ok || cur_sz < best_sz)) begin
          best    <= ptr[GW-1:0];
          best_sz <= cur_sz;
          best_ok <= 1'b1;
        end
        ptr <= ptr + cur_sz;
      end
      bfpa_pkg::OP_FREE_EVAL: begin
        prev      <= ptr[GW-1:0];
        prev_ok   <= 1'b1;
        prev_used <= cur_used;
        prev_sz   <= cur_sz;
        ptr       <= ptr + cur_sz;
      end
      bfpa_pkg::OP_FREE_HIT: begin
        g_sz <= cur_sz;
      end
      bfpa_pkg::OP_FREE_NLATCH: begin
        nfree <= !cur_used;
        nsz   <= cur_sz;
      end
      bfpa_pkg::OP_STAT_INIT: begin
        ptr   <= '0;
        sum   <= '0;
        maxsz <= '0;
      end
      bfpa_pkg::OP_STAT_EVAL: begin
        if (!cur_used) begin
          sum <= sum + cur_sz;
          if (cur_sz > maxsz) begin
            maxsz <= cur_sz;
          end
        end
        ptr <= ptr + cur_sz;
      end
      bfpa_pkg::OP_RESULT: begin
        out_status             <= st;
        out_granted_offset     <= (st == bfpa_pkg::ST_OK && alloc) ?
                                  12'({best, bfpa_pkg::GSH'(0)}) +
                                  12'(bfpa_pkg::HEADER_BYTES) : '0;
        out_total_free_bytes   <= 13'({sum, bfpa_pkg::GSH'(0)});
        out_largest_free_bytes <= 13'({maxsz, bfpa_pkg::GSH'(0)});
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/best_fit_pool_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_pool_allocator_unit
// Best-fit allocator over a 4 KiB pool of 8-byte granules.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: tuser is the request type (0 allocate,
// 1 free), tdata carries the byte count and the release offset. Each request
// gives one result transaction on the m_ stream: status, granted offset, total
// free bytes and largest free block.
// The APB port holds min_split_bytes at address 0; write it only while idle.
// One request is in work at a time. Each block on the chain takes one registered
// memory read and one evaluation step, and the chain is walked once for the
// search and once more for the statistics; the longest chain has 171 blocks
// (every used block at least 5 granules).
// A new request is taken while a result still waits on the m_ side; a stall
// there holds the finished result and then halts the sequencer at its end.
// Reset makes the whole pool one free block at once; no clearing pass.
// ----------------------------------------------------------------------------
module best_fit_pool_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [12:0] request_bytes, [24:13] release_offset
  input  logic        s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [1:0] status, [13:2] granted_offset,
                                 // [26:14] total_free_bytes, [39:27] largest_free_bytes
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  bfpa_pkg::cmd_t   cmd;
  bfpa_pkg::flags_t flags;
  logic [12:0]      min_split_bytes;

  assign pready = 1'b1;
  assign prdata = (paddr == bfpa_pkg::ADDR_MIN_SPLIT) ? {19'd0, min_split_bytes} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_split_bytes <= 13'd32;
    end else if (psel && penable && pwrite && paddr == bfpa_pkg::ADDR_MIN_SPLIT) begin
      min_split_bytes <= pwdata[12:0];
    end
  end

  bfpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .flags    (flags),
    .cmd      (cmd)
  );

  bfpa_datapath u_dp (
    .clk                    (clk),
    .rst                    (rst),
    .cmd                    (cmd),
    .flags                  (flags),
    .in_req_type            (s_tuser),
    .in_request_bytes       (s_tdata[12:0]),
    .in_release_offset      (s_tdata[24:13]),
    .min_split_bytes        (min_split_bytes),
    .out_valid              (m_tvalid),
    .out_ready              (m_tready),
    .out_status             (m_tdata[1:0]),
    .out_granted_offset     (m_tdata[13:2]),
    .out_total_free_bytes   (m_tdata[26:14]),
    .out_largest_free_bytes (m_tdata[39:27])
  );

endmodule

// ===== hw/rtl/bfpa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "best_fit_pool_allocator_unit_defines.svh"

module bfpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // a stalled result holds
  `BFPA_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  // nothing on the output straight after reset
  `BFPA_ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> !m_tvalid)
  // a result whose status is not OK carries no offset
  `BFPA_ASSERT(a_offset, clk, rst, m_tvalid && m_tdata[1:0] != bfpa_pkg::ST_OK |-> m_tdata[13:2] == 12'd0)
  // largest free block never exceeds the total
  `BFPA_ASSERT(a_largest, clk, rst, m_tvalid |-> m_tdata[39:27] <= m_tdata[26:14])

endmodule

bind best_fit_pool_allocator_unit bfpa_checker u_bfpa_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the best-fit pool allocator.
// ----------------------------------------------------------------------------
// Requests go in on the s_ stream from a queue that an initial block fills.
// A local model of the block table predicts every result at the accepting
// edge, and each m_ transaction is checked against the oldest prediction.
// The run steps through several min_split_bytes settings over APB, mixing
// well-formed allocate/free sequences with bad sizes and bogus offsets, and
// random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic        is_free;
    logic [12:0] nbytes;
    logic [11:0] offset;
  } alloc_req_t;

  typedef struct {
    bfpa_pkg::status_t st;
    logic [11:0]       grant;
    logic [12:0]       total;
    logic [12:0]       largest;
  } alloc_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [12:0] request_bytes, [24:13] release_offset
  logic        s_tuser = 1'b0; // [0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [1:0] status, [13:2] granted_offset,
                               // [26:14] total_free_bytes, [39:27] largest_free_bytes
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  best_fit_pool_allocator_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #100ms;
    $display("tb_top failed");
    $finish;
  end

  // shadow of the block table
  bit         start_mark [bfpa_pkg::NGRAN];
  bit         used_mark  [bfpa_pkg::NGRAN];
  int         blk_gran   [bfpa_pkg::NGRAN];
  int         min_split;

  alloc_req_t req_q[$];
  alloc_rsp_t rsp_q[$];
  int         live_offsets[$];
  int         n_fail = 0;
  int         n_req = 0, n_rsp = 0;
  int         n_alloc_ok = 0, n_free_ok = 0, n_nofit = 0, n_badreq = 0, n_badfree = 0;
  bit         in_took = 0, out_took = 0;

  function automatic void pool_stats(output int total, output int largest);
    int g;
    g = 0; total = 0; largest = 0;
    while (g < bfpa_pkg::NGRAN && blk_gran[g] != 0) begin
      if (!used_mark[g]) begin
        total += blk_gran[g];
        if (blk_gran[g] > largest) largest = blk_gran[g];
      end
      g += blk_gran[g];
    end
    total *= bfpa_pkg::GRANULE_BYTES;
    largest *= bfpa_pkg::GRANULE_BYTES;
  endfunction

  function automatic bfpa_pkg::status_t grant_block(int nbytes, output int offset);
    int need, g, best, best_sz, left;
    offset = 0;
    need = (nbytes + bfpa_pkg::HEADER_BYTES + bfpa_pkg::GRANULE_BYTES - 1)
           / bfpa_pkg::GRANULE_BYTES;
    if (nbytes == 0 || need > bfpa_pkg::NGRAN) return bfpa_pkg::ST_BADREQ;
    best = bfpa_pkg::NGRAN; best_sz = 0; g = 0;
    while (g < bfpa_pkg::NGRAN && blk_gran[g] != 0) begin
      if (!used_mark[g] && blk_gran[g] >= need &&
          (best == bfpa_pkg::NGRAN || blk_gran[g] < best_sz)) begin
        best = g;
        best_sz = blk_gran[g];
      end
      g += blk_gran[g];
    end
    if (best == bfpa_pkg::NGRAN) return bfpa_pkg::ST_NOFIT;
    left = best_sz - need;
    if (left > 0 && left * bfpa_pkg::GRANULE_BYTES >= min_split) begin
      start_mark[best + need] = 1;
      used_mark[best + need] = 0;
      blk_gran[best + need] = left;
      blk_gran[best] = need;
    end
    used_mark[best] = 1;
    offset = best * bfpa_pkg::GRANULE_BYTES + bfpa_pkg::HEADER_BYTES;
    return bfpa_pkg::ST_OK;
  endfunction

  function automatic bfpa_pkg::status_t release_block(int off);
    int g, n, p, prev;
    if (off < bfpa_pkg::HEADER_BYTES ||
        (off - bfpa_pkg::HEADER_BYTES) % bfpa_pkg::GRANULE_BYTES != 0)
      return bfpa_pkg::ST_BADFREE;
    g = (off - bfpa_pkg::HEADER_BYTES) / bfpa_pkg::GRANULE_BYTES;
    if (g >= bfpa_pkg::NGRAN || !start_mark[g] || !used_mark[g]) return bfpa_pkg::ST_BADFREE;
    used_mark[g] = 0;
    n = g + blk_gran[g];
    if (n < bfpa_pkg::NGRAN && start_mark[n] && !used_mark[n]) begin
      blk_gran[g] += blk_gran[n];
      start_mark[n] = 0;
      blk_gran[n] = 0;
    end
    prev = bfpa_pkg::NGRAN; p = 0;
    while (p < g && blk_gran[p] != 0) begin
      prev = p;
      p += blk_gran[p];
    end
    if (prev < g && !used_mark[prev]) begin
      blk_gran[prev] += blk_gran[g];
      start_mark[g] = 0;
      blk_gran[g] = 0;
    end
    return bfpa_pkg::ST_OK;
  endfunction

  // input driver
  int in_gap = 0;
  int in_burst = 0;
  always @(negedge clk) begin
    alloc_req_t r;
    logic nv;
    nv = s_tvalid;
    if (!rst) begin
      if (s_tvalid && in_took) nv = 1'b0;
      if (!nv || (s_tvalid && in_took)) begin
        if (in_gap > 0) begin
          in_gap--;
          nv = 1'b0;
        end else if (req_q.size() > 0) begin
          r = req_q.pop_front();
          s_tuser <= r.is_free;
          s_tdata <= {7'b0, r.offset, r.nbytes};
          nv = 1'b1;
          in_burst = (in_burst + 1) % 64;
          in_gap = (in_burst < 20) ? 0 : $urandom_range(0, 17);
        end
      end
    end
    s_tvalid <= nv;
  end

  // output stall control
  int out_stall = 0;
  always @(negedge clk) begin
    logic nr;
    nr = m_tready;
    if (!rst) begin
      if (out_took) begin
        if (n_rsp == 300) out_stall = 700;
        else if ((n_rsp % 80) < 25) out_stall = 0;
        else out_stall = $urandom_range(0, 17);
      end
      if (out_stall > 0) begin
        out_stall--;
        nr = 1'b0;
      end else nr = 1'b1;
    end
    m_tready <= nr;
  end

  // predict on input, check on output
  always @(posedge clk) begin
    alloc_rsp_t e;
    int off, tot, big, k;
    in_took <= !rst && s_tvalid && s_tready;
    out_took <= !rst && m_tvalid && m_tready;
    if (!rst && s_tvalid && s_tready) begin
      n_req++;
      if (s_tuser == 1'b0) begin
        e.st = grant_block(int'(s_tdata[12:0]), off);
        if (e.st == bfpa_pkg::ST_OK) live_offsets.push_back(off);
      end else begin
        off = 0;
        e.st = release_block(int'(s_tdata[24:13]));
        if (e.st == bfpa_pkg::ST_OK)
          for (k = 0; k < live_offsets.size(); k++)
            if (live_offsets[k] == int'(s_tdata[24:13])) begin
              live_offsets.delete(k);
              break;
            end
      end
      case (e.st)
        bfpa_pkg::ST_OK:     if (s_tuser) n_free_ok++; else n_alloc_ok++;
        bfpa_pkg::ST_NOFIT:  n_nofit++;
        bfpa_pkg::ST_BADREQ: n_badreq++;
        default:             n_badfree++;
      endcase
      pool_stats(tot, big);
      e.grant = off[11:0];
      e.total = tot[12:0];
      e.largest = big[12:0];
      rsp_q.push_back(e);
    end
    if (!rst && m_tvalid && m_tready) begin
      n_rsp++;
      if (rsp_q.size() == 0) begin
        $error("unexpected result transaction %h", m_tdata);
        n_fail++;
      end else begin
        e = rsp_q.pop_front();
        if (m_tdata[1:0] != e.st) begin
          $error("status: expected %0d, got %0d", e.st, m_tdata[1:0]);
          n_fail++;
        end
        if (m_tdata[13:2] != e.grant) begin
          $error("granted_offset: expected %0d, got %0d", e.grant, m_tdata[13:2]);
          n_fail++;
        end
        if (m_tdata[26:14] != e.total) begin
          $error("total_free_bytes: expected %0d, got %0d", e.total, m_tdata[26:14]);
          n_fail++;
        end
        if (m_tdata[39:27] != e.largest) begin
          $error("largest_free_bytes: expected %0d, got %0d", e.largest, m_tdata[39:27]);
          n_fail++;
        end
      end
    end
  end

  task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
    psel <= 1'b1; paddr <= a;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[12:0] != d[12:0]) begin
      $error("min_split_bytes readback: expected %0d, got %0d", d[12:0], prdata[12:0]);
      n_fail++;
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
    min_split = int'(d[12:0]);
  endtask

  task automatic push_req(input logic is_free, input int nbytes, input int offset);
    alloc_req_t r;
    while (req_q.size() > 1) @(posedge clk);
    r.is_free = is_free;
    r.nbytes = nbytes[12:0];
    r.offset = offset[11:0];
    req_q.push_back(r);
  endtask

  task automatic drain;
    while (req_q.size() > 0 || rsp_q.size() > 0 || s_tvalid) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int i, sel, nb;
    for (i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        case ($urandom_range(0, 9))
          0:       nb = $urandom_range(0, 8191);
          1:       nb = $urandom_range(1000, 4096);
          2:       nb = 0;
          default: nb = $urandom_range(1, 300);
        endcase
        push_req(1'b0, nb, $urandom_range(0, 4095));
      end else if (sel < 88 && live_offsets.size() > 0) begin
        push_req(1'b1, $urandom_range(0, 8191),
                 live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
      end else begin
        push_req(1'b1, $urandom_range(0, 8191), $urandom_range(0, 4095));
      end
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < bfpa_pkg::NGRAN; i++) begin
      start_mark[i] = 0; used_mark[i] = 0; blk_gran[i] = 0;
    end
    start_mark[0] = 1;
    blk_gran[0] = bfpa_pkg::NGRAN;
    min_split = 32;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    apb_write(bfpa_pkg::ADDR_MIN_SPLIT, 32);
    push_req(1'b0, 0, 0);          // zero request
    push_req(1'b0, 4096, 0);       // too large once the header is added
    push_req(1'b0, 8191, 4095);
    push_req(1'b0, 4064, 0);       // whole pool, nothing left over
    push_req(1'b0, 1, 0);          // no fit
    push_req(1'b1, 0, 32);
    push_req(1'b1, 0, 32);         // already free
    push_req(1'b1, 0, 0);          // below header
    push_req(1'b1, 0, 33);         // off grid
    push_req(1'b1, 0, 4095);
    push_req(1'b0, 1, 0);
    push_req(1'b0, 100, 0);
    push_req(1'b0, 5, 0);
    push_req(1'b0, 3800, 0);
    push_req(1'b1, 0, 72);         // middle block
    push_req(1'b1, 0, 32);         // merges with next
    push_req(1'b0, 60, 0);         // leftover at or above threshold splits off
    push_req(1'b1, 0, 4064);       // inside the large block, not at a block start
    random_phase(250);
    drain;

    apb_write(bfpa_pkg::ADDR_MIN_SPLIT, 0);
    random_phase(280);
    drain;
    apb_write(bfpa_pkg::ADDR_MIN_SPLIT, 4096);
    random_phase(200);
    drain;
    apb_write(bfpa_pkg::ADDR_MIN_SPLIT, $urandom_range(0, 4096));
    random_phase(300);
    drain;
    apb_write(bfpa_pkg::ADDR_MIN_SPLIT, 8);
    random_phase(300);
    drain;

    $display("covered %0d requests: %0d grants, %0d releases, %0d no-fit,",
             n_req, n_alloc_ok, n_free_ok, n_nofit);
    $display("  %0d bad sizes, %0d bad releases, five split thresholds", n_badreq, n_badfree);
    if (n_fail == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
